// ===== hw/rtl/efla_pkg.sv =====
// Shared types and constants for the extent free-list allocator.
package efla_pkg;

    localparam int FREE_ENTRIES = 64;
    localparam int IDX_W        = $clog2(FREE_ENTRIES);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic CFG_COALESCE = 1'b0;
    localparam logic CFG_THRESH   = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [31:0] start;
        logic [15:0] count;
    } t_entry;

endpackage

// ===== hw/rtl/efla_cell.sv =====
// One table slot: holds an extent and passes it to its neighbor while the ring turns.
module efla_cell import efla_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_nbr,
    input  logic   i_wr,
    input  t_entry i_wdata,
    input  logic   i_kill,
    output t_entry o_entry
);

    logic        r_valid;
    logic [31:0] r_start;
    logic [15:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_nbr.valid;
        end else if (i_kill) begin
            r_valid <= 1'b0;
        end else if (i_wr) begin
            r_valid <= i_wdata.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_start <= i_nbr.start;
            r_count <= i_nbr.count;
        end else if (i_wr) begin
            r_start <= i_wdata.start;
            r_count <= i_wdata.count;
        end
    end

    assign o_entry = '{valid: r_valid, start: r_start, count: r_count};

endmodule

// ===== hw/rtl/extent_free_list_allocator_unit.sv =====
// Best-fit free-extent allocator: a request is taken only while the unit is idle. Its result is
// loaded into the output register after one full turn of the ring of slot cells past the compare
// unit at its head, then in the update cycle. The update cycle waits while an earlier result is
// still stalled at the output. A clear skips the turn and goes straight to the update cycle.
// The next request is taken in the cycle after the load.
module extent_free_list_allocator_unit import efla_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_extent_start,
    input  logic [15:0] i_extent_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_start,
    output logic [15:0] o_result_count,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]       r_state;
    logic [IDX_W-1:0] r_cnt;
    logic             r_coal;
    logic [15:0]      r_thr;
    logic [1:0]       r_op;
    logic [31:0]      r_s;
    logic [15:0]      r_c;
    logic [17:0]      r_need2;

    // scan captures
    logic r_f1v, r_f2v, r_nv, r_pv, r_dup, r_fsv;
    logic [IDX_W-1:0] r_f1i, r_f2i, r_ni, r_pi, r_fsi;
    logic [31:0] r_f1s, r_f2s, r_ns, r_ps;
    logic [15:0] r_f1c, r_f2c, r_nc, r_pc, r_clo;

    logic        r_ovalid;
    logic [1:0]  r_ostatus;
    logic [31:0] r_ostart;
    logic [15:0] r_ocount;

    t_entry cells [FREE_ENTRIES];
    t_entry hd;
    logic   shift, upd_go, accept;

    assign hd     = cells[0];
    assign shift  = (r_state == S_SCAN);
    assign upd_go = (r_state == S_UPD) && (!r_ovalid || !i_stall);
    assign o_stall = (r_state != S_IDLE);
    assign accept = i_valid && (r_state == S_IDLE);

    // update decision
    logic        a_en, b_en, clr;
    logic [IDX_W-1:0] a_idx, b_idx;
    t_entry      a_data;
    logic [1:0]  d_status;
    logic [31:0] d_start;
    logic [15:0] d_count;
    logic        use1;
    logic [16:0] nsum, psum;
    logic        with_next;
    logic [15:0] cc;

    always_comb begin
        a_en = 1'b0; b_en = 1'b0; clr = 1'b0;
        a_idx = r_fsi; b_idx = r_ni;
        a_data = '{valid: 1'b1, start: r_s, count: r_c};
        d_status = ST_OK; d_start = 32'd0; d_count = 16'd0;
        use1 = r_f1v && ((r_f1c == r_c) || ((r_f1c - r_c) > r_thr));
        nsum = {1'b0, r_c} + {1'b0, r_nc};
        with_next = r_nv && (({1'b0, r_s} + {17'd0, r_c}) == {1'b0, r_ns}) && !nsum[16];
        cc = with_next ? nsum[15:0] : r_c;
        psum = {1'b0, r_pc} + {1'b0, cc};
        case (r_op)
            OP_ALLOC: begin
                if (use1) begin
                    a_en = 1'b1; a_idx = r_f1i;
                    d_start = r_f1s; d_count = r_c;
                    a_data = '{valid: (r_f1c != r_c), start: r_f1s + {16'd0, r_c},
                               count: r_f1c - r_c};
                end else if (r_f1v && r_f2v) begin
                    a_en = 1'b1; a_idx = r_f2i;
                    d_start = r_f2s; d_count = r_c;
                    a_data = '{valid: 1'b1, start: r_f2s + {16'd0, r_c},
                               count: r_f2c - r_c};
                end else begin
                    d_status = ST_NOFIT; d_count = r_clo;
                end
            end
            OP_CLEAR: clr = 1'b1;
            default: begin
                if (r_op == OP_FREE && r_coal && r_pv && !psum[16] &&
                    (({1'b0, r_ps} + {17'd0, r_pc}) == {1'b0, r_s})) begin
                    a_en = 1'b1; a_idx = r_pi;
                    a_data = '{valid: 1'b1, start: r_ps, count: psum[15:0]};
                    b_en = with_next;
                end else if (r_op == OP_FREE && r_coal && with_next) begin
                    a_en = !r_dup; a_idx = r_ni;
                    a_data = '{valid: 1'b1, start: r_s, count: cc};
                end else if (!r_dup) begin
                    if (r_fsv) a_en = 1'b1;
                    else d_status = ST_FULL;
                end
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < FREE_ENTRIES; gi++) begin : g_cell
            localparam int NX = (gi + 1) % FREE_ENTRIES;
            efla_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_nbr   (cells[NX]),
                .i_wr    (upd_go && a_en && (a_idx == IDX_W'(gi))),
                .i_wdata (a_data),
                .i_kill  (upd_go && (clr || (b_en && (b_idx == IDX_W'(gi))))),
                .o_entry (cells[gi])
            );
        end
    endgenerate

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_coal   <= 1'b1;
            r_thr    <= 16'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_COALESCE) r_coal <= i_cfg_wdata[0];
                else r_thr <= i_cfg_wdata;
            end
            // load a new result, or drop the one just transferred
            if (upd_go) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cnt   <= '0;
                        r_state <= (i_opcode == OP_CLEAR) ? S_UPD : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IDX_W'(FREE_ENTRIES - 1)) r_state <= S_UPD;
                end
                S_UPD: begin
                    if (upd_go) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // request latch, scan compares and result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_opcode;
            r_s     <= i_extent_start;
            r_c     <= i_extent_count;
            r_need2 <= {2'b0, i_extent_count} + {2'b0, r_thr} + 18'd1;
            r_f1v <= 1'b0; r_f2v <= 1'b0; r_nv <= 1'b0; r_pv <= 1'b0;
            r_dup <= 1'b0; r_fsv <= 1'b0; r_clo <= 16'd0;
        end else if (shift) begin
            if (hd.valid && hd.count >= r_c &&
                (!r_f1v || hd.count < r_f1c || (hd.count == r_f1c && hd.start < r_f1s))) begin
                r_f1v <= 1'b1; r_f1i <= r_cnt; r_f1s <= hd.start; r_f1c <= hd.count;
            end
            if (hd.valid && {2'b0, hd.count} >= r_need2 &&
                (!r_f2v || hd.count < r_f2c || (hd.count == r_f2c && hd.start < r_f2s))) begin
                r_f2v <= 1'b1; r_f2i <= r_cnt; r_f2s <= hd.start; r_f2c <= hd.count;
            end
            if (hd.valid && hd.count < r_c && hd.count > r_clo) r_clo <= hd.count;
            if (hd.valid && hd.start > r_s && (!r_nv || hd.start < r_ns)) begin
                r_nv <= 1'b1; r_ni <= r_cnt; r_ns <= hd.start; r_nc <= hd.count;
            end
            if (hd.valid && hd.start <= r_s && (!r_pv || hd.start > r_ps)) begin
                r_pv <= 1'b1; r_pi <= r_cnt; r_ps <= hd.start; r_pc <= hd.count;
            end
            if (hd.valid && hd.start == r_s) r_dup <= 1'b1;
            if (!hd.valid && !r_fsv) begin
                r_fsv <= 1'b1; r_fsi <= r_cnt;
            end
        end
        if (upd_go) begin
            r_ostatus <= d_status;
            r_ostart  <= d_start;
            r_ocount  <= d_count;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_result_start = r_ostart;
    assign o_result_count = r_ocount;

endmodule
